@@ rtl/can_id_stats_table_top_assert.svh @@
// Assertion macros for the identifier statistics table.
// CIS_ASSERT_IMP checks a same-cycle implication, CIS_ASSERT_NXT a next-cycle one.
`ifndef CAN_ID_STATS_TABLE_TOP_ASSERT_SVH
`define CAN_ID_STATS_TABLE_TOP_ASSERT_SVH
`ifndef SYNTH
`define CIS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define CIS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define CIS_ASSERT_IMP(label, clk, rst, ante, cons)
`define CIS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/cis_pkg.sv @@
package cis_pkg;

   localparam int SLOTS_DEF = 64;

   localparam int ID_W     = 29;
   localparam int LEN_W    = 4;
   localparam int FLAGS_W  = 16;
   localparam int STAMP_W  = 32;
   localparam int DATA_W   = 64;
   localparam int SLOT_W   = 6;

   // divide-by-five unit: padded numerator, bits retired per cycle
   localparam int DIV_W     = 40;
   localparam int DIV_DIGIT = 8;

   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_QUERY   = 1'b1;

   typedef enum logic [1:0] {
      STAT_MATCH = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // one slot of the statistics store
   typedef struct packed {
      logic [DATA_W-1:0]  payload;
      logic [LEN_W-1:0]   length;
      logic [FLAGS_W-1:0] flags;
      logic [STAMP_W-1:0] stamp;
      logic [STAMP_W-1:0] last_arrival;
      logic [STAMP_W-1:0] delta_stamp;
      logic [STAMP_W-1:0] delta_arrival;
      logic [STAMP_W-1:0] avg_stamp;
      logic [STAMP_W-1:0] avg_arrival;
   } entry_type;

   // identifier scan outcome
   typedef struct packed {
      logic done;
      logic found;
      logic full;
   } scan_status_type;

endpackage

@@ rtl/cis_slot_mem.sv @@
module cis_slot_mem #(
   parameter  int SLOTS = cis_pkg::SLOTS_DEF,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output cis_pkg::entry_type  rd_data,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  cis_pkg::entry_type  wr_data
);
   import cis_pkg::*;

   entry_type mem [SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cis_id_scan.sv @@
module cis_id_scan #(
   parameter  int SLOTS = cis_pkg::SLOTS_DEF,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int CNT_W = $clog2(SLOTS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [cis_pkg::ID_W-1:0] frame_id,
   input  logic [CNT_W-1:0]         fill,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic [cis_pkg::ID_W-1:0] wr_id,
   output cis_pkg::scan_status_type scan_st,
   output logic [IDX_W-1:0]         scan_idx
);
   import cis_pkg::*;

   logic [ID_W-1:0]  id_mem [SLOTS];
   logic [ID_W-1:0]  rd_id_ff;
   logic [ID_W-1:0]  key_ff;
   logic             active_ff;
   logic             chk_ff;
   logic [CNT_W-1:0] issue_ff;
   logic [IDX_W-1:0] chk_addr_ff;
   logic             issue_go;
   logic             hit;
   logic             exhausted;

   // only slots below the fill count hold live identifiers
   assign issue_go  = active_ff && (issue_ff < fill);
   assign hit       = active_ff && chk_ff && (rd_id_ff == key_ff);
   assign exhausted = active_ff && !chk_ff && (issue_ff == fill);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[wr_addr] <= wr_id;
      end
      if (issue_go) begin
         rd_id_ff <= id_mem[issue_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         chk_ff    <= 1'b0;
      end else if (start) begin
         active_ff <= 1'b1;
         chk_ff    <= 1'b0;
         issue_ff  <= '0;
         key_ff    <= frame_id;
      end else if (hit || exhausted) begin
         active_ff <= 1'b0;
         chk_ff    <= 1'b0;
      end else begin
         chk_ff <= issue_go;
         if (issue_go) begin
            issue_ff    <= issue_ff + 1'b1;
            chk_addr_ff <= issue_ff[IDX_W-1:0];
         end
      end
   end

   assign scan_st.done  = hit || exhausted;
   assign scan_st.found = hit;
   assign scan_st.full  = exhausted && (fill == CNT_W'(SLOTS));
   assign scan_idx      = hit ? chk_addr_ff : fill[IDX_W-1:0];

endmodule

@@ rtl/cis_div5.sv @@
module cis_div5 (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [cis_pkg::STAMP_W-1:0] delta,
   input  logic signed [cis_pkg::STAMP_W-1:0] old,
   output logic                               done,
   output logic signed [cis_pkg::STAMP_W-1:0] average
);
   import cis_pkg::*;

   localparam int SUM_W  = STAMP_W + 3;
   localparam int STEPS  = DIV_W / DIV_DIGIT;
   localparam int STEP_W = $clog2(STEPS + 1);
   localparam logic [3:0] DIVISOR = 4'd5;

   logic signed [SUM_W-1:0] sum;
   logic        [SUM_W-1:0] mag;
   logic        [DIV_W-1:0] num_ff;
   logic        [DIV_W-1:0] quo_ff;
   logic        [2:0]       rem_ff;
   logic                    neg_ff;
   logic                    busy_ff;
   logic                    done_ff;
   logic        [STEP_W-1:0] step_ff;
   logic        [DIV_W-1:0] num_in;
   logic        [DIV_W-1:0] quo_in;
   logic        [2:0]       rem_in;

   // 2*delta + 3*old, exact
   assign sum = (SUM_W'(delta) <<< 1) + SUM_W'(old) + (SUM_W'(old) <<< 1);
   assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

   // restoring division, one digit of DIV_DIGIT bits per cycle
   always_comb begin
      logic [3:0] part;
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int j = 0; j < DIV_DIGIT; j++) begin
         part   = {rem_in, num_in[DIV_W-1]};
         num_in = num_in << 1;
         if (part >= DIVISOR) begin
            part   = part - DIVISOR;
            quo_in = {quo_in[DIV_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_in[DIV_W-2:0], 1'b0};
         end
         rem_in = part[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
         num_ff  <= DIV_W'(mag);
         quo_ff  <= '0;
         rem_ff  <= '0;
         neg_ff  <= sum[SUM_W-1];
      end else if (busy_ff) begin
         num_ff  <= num_in;
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + 1'b1;
         if (step_ff == STEP_W'(STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // truncation toward zero: divide the magnitude, then restore the sign
   assign done    = done_ff;
   assign average = neg_ff ? -quo_ff[STAMP_W-1:0] : quo_ff[STAMP_W-1:0];

endmodule

@@ rtl/can_id_stats_table_top.sv @@
// Channel | Direction | Handshake           | Word
// req_    | in        | req_valid/req_stall | opcode, identifier, frame fields, ms clock
// rsp_    | out       | rsp_valid/rsp_stall | status, slot, deltas, averages, slot contents
//
// One word at a time. fill is the number of occupied slots: the identifier scan
// reads one slot identifier a cycle from its memory, then comes one read-modify-write
// of the slot memory with a divide-by-five unit.
// A query skips the divide and write back; a full table answers straight after the scan.
// Synchronous reset empties the table at once through the fill count; no clearing pass.
// req_stall is high from acceptance until the result is in the output register, so a
// new word is taken while an earlier result still waits behind rsp_stall.
`include "can_id_stats_table_top_assert.svh"

module can_id_stats_table_top #(
   parameter  int SLOTS = cis_pkg::SLOTS_DEF,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int CNT_W = $clog2(SLOTS + 1)
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [cis_pkg::ID_W-1:0]            req_frame_id,
   input  logic [cis_pkg::LEN_W-1:0]           req_length_code,
   input  logic [cis_pkg::FLAGS_W-1:0]         req_frame_flags,
   input  logic [cis_pkg::STAMP_W-1:0]         req_frame_stamp,
   input  logic [cis_pkg::STAMP_W-1:0]         req_arrival_ms,
   input  logic [cis_pkg::DATA_W-1:0]          req_payload,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [cis_pkg::SLOT_W-1:0]          rsp_slot,
   output logic                                rsp_payload_changed,
   output logic signed [cis_pkg::STAMP_W-1:0]  rsp_arrival_delta,
   output logic signed [cis_pkg::STAMP_W-1:0]  rsp_stamp_delta,
   output logic signed [cis_pkg::STAMP_W-1:0]  rsp_arrival_average,
   output logic signed [cis_pkg::STAMP_W-1:0]  rsp_stamp_average,
   output logic [cis_pkg::LEN_W-1:0]           rsp_stored_length,
   output logic [cis_pkg::FLAGS_W-1:0]         rsp_stored_flags,
   output logic [cis_pkg::STAMP_W-1:0]         rsp_stored_stamp,
   output logic [cis_pkg::DATA_W-1:0]          rsp_stored_payload
);
   import cis_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_READ,
      S_CALC,
      S_START,
      S_DIV,
      S_WRITE,
      S_FINISH
   } state_type;

   state_type        state_ff;

   // occupancy: slots below fill_ff hold a non-zero identifier. dirty_ff marks that
   // the slot at fill_ff was written by a zero identifier and keeps its contents.
   logic [CNT_W-1:0] fill_ff;
   logic             dirty_ff;

   // latched request word
   logic                op_ff;
   logic [ID_W-1:0]     id_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [FLAGS_W-1:0]  flags_ff;
   logic [STAMP_W-1:0]  stamp_ff;
   logic [STAMP_W-1:0]  arrival_ff;
   logic [DATA_W-1:0]   data_ff;

   // scan outcome and slot working copy
   logic                found_ff;
   logic                full_ff;
   logic [IDX_W-1:0]    idx_ff;
   entry_type           old_ff;
   entry_type           res_ff;
   logic                changed_ff;
   logic [STAMP_W-1:0]  da_ff;
   logic [STAMP_W-1:0]  ds_ff;

   // output register
   logic                rsp_valid_ff;
   status_type          status_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic                rsp_changed_ff;
   entry_type           rsp_entry_ff;

   logic                req_accept;
   logic                rsp_free;
   scan_status_type     scan_st;
   logic [IDX_W-1:0]    scan_idx;
   logic                mem_rd_en;
   entry_type           mem_rd;
   entry_type           new_entry;
   logic                div_start;
   logic                div_a_done;
   logic                div_s_done;
   logic signed [STAMP_W-1:0] avg_a;
   logic signed [STAMP_W-1:0] avg_s;
   status_type          status_in;

   assign req_stall  = reset || (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // identifier scan over the occupied slots
   cis_id_scan #(.SLOTS(SLOTS)) u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .frame_id (req_frame_id),
      .fill     (fill_ff),
      .wr_en    (state_ff == S_WRITE),
      .wr_addr  (idx_ff),
      .wr_id    (id_ff),
      .scan_st  (scan_st),
      .scan_idx (scan_idx)
   );

   // slot contents: read issued as the scan ends, written back after the divide
   assign mem_rd_en = (state_ff == S_SCAN) && scan_st.done && !scan_st.full;

   cis_slot_mem #(.SLOTS(SLOTS)) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (scan_idx),
      .rd_data (mem_rd),
      .wr_en   (state_ff == S_WRITE),
      .wr_addr (idx_ff),
      .wr_data (new_entry)
   );

   // moving averages, arrival lane and timestamp lane
   assign div_start = (state_ff == S_START);

   cis_div5 u_div_arrival (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .delta   (da_ff),
      .old     (old_ff.avg_arrival),
      .done    (div_a_done),
      .average (avg_a)
   );

   cis_div5 u_div_stamp (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .delta   (ds_ff),
      .old     (old_ff.avg_stamp),
      .done    (div_s_done),
      .average (avg_s)
   );

   always_comb begin
      new_entry.payload       = data_ff;
      new_entry.length        = len_ff;
      new_entry.flags         = flags_ff;
      new_entry.stamp         = stamp_ff;
      new_entry.last_arrival  = arrival_ff;
      new_entry.delta_stamp   = ds_ff;
      new_entry.delta_arrival = da_ff;
      new_entry.avg_stamp     = avg_s;
      new_entry.avg_arrival   = avg_a;
   end

   always_comb begin
      if (full_ff) begin
         status_in = STAT_FULL;
      end else if (found_ff) begin
         status_in = STAT_MATCH;
      end else begin
         status_in = STAT_EMPTY;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff      <= req_opcode;
         id_ff      <= req_frame_id;
         len_ff     <= req_length_code;
         flags_ff   <= req_frame_flags;
         stamp_ff   <= req_frame_stamp;
         arrival_ff <= req_arrival_ms;
         data_ff    <= req_payload;
      end
      if ((state_ff == S_SCAN) && scan_st.done) begin
         found_ff   <= scan_st.found;
         full_ff    <= scan_st.full;
         idx_ff     <= scan_st.full ? '0 : scan_idx;
         res_ff     <= '0;
         changed_ff <= 1'b0;
      end
      // an empty slot at the fill mark reads as zero unless a zero identifier wrote it
      if (state_ff == S_READ) begin
         old_ff <= (found_ff || dirty_ff) ? mem_rd : '0;
      end
      // differences wrap modulo 2^32
      if (state_ff == S_CALC) begin
         da_ff <= arrival_ff - old_ff.last_arrival;
         ds_ff <= stamp_ff - old_ff.stamp;
         if (op_ff == OP_QUERY) begin
            res_ff     <= old_ff;
            changed_ff <= 1'b0;
         end
      end
      if (state_ff == S_WRITE) begin
         res_ff     <= new_entry;
         changed_ff <= (old_ff.payload != data_ff);
      end
   end

   // sequencer, occupancy and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         dirty_ff     <= 1'b0;
      end else begin
         // in S_FINISH the register is reloaded as soon as it frees
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (scan_st.done) begin
                  state_ff <= scan_st.full ? S_FINISH : S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_CALC;
            end
            S_CALC: begin
               state_ff <= (op_ff == OP_QUERY) ? S_FINISH : S_START;
            end
            S_START: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_a_done && div_s_done) begin
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               state_ff <= S_FINISH;
               // a zero identifier uses the empty slot but leaves it empty
               if (!found_ff) begin
                  if (id_ff != '0) begin
                     fill_ff  <= fill_ff + 1'b1;
                     dirty_ff <= 1'b0;
                  end else begin
                     dirty_ff <= 1'b1;
                  end
               end
            end
            S_FINISH: begin
               if (rsp_free) begin
                  rsp_valid_ff   <= 1'b1;
                  status_ff      <= status_in;
                  slot_ff        <= SLOT_W'(idx_ff);
                  rsp_changed_ff <= changed_ff;
                  rsp_entry_ff   <= res_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_slot            = slot_ff;
   assign rsp_payload_changed = rsp_changed_ff;
   assign rsp_arrival_delta   = rsp_entry_ff.delta_arrival;
   assign rsp_stamp_delta     = rsp_entry_ff.delta_stamp;
   assign rsp_arrival_average = rsp_entry_ff.avg_arrival;
   assign rsp_stamp_average   = rsp_entry_ff.avg_stamp;
   assign rsp_stored_length   = rsp_entry_ff.length;
   assign rsp_stored_flags    = rsp_entry_ff.flags;
   assign rsp_stored_stamp    = rsp_entry_ff.stamp;
   assign rsp_stored_payload  = rsp_entry_ff.payload;

   `CIS_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= CNT_W'(SLOTS))
   `CIS_ASSERT_IMP(a_full_needs_fill, clock, reset, scan_st.done && scan_st.full, fill_ff == CNT_W'(SLOTS))
   `CIS_ASSERT_IMP(a_hit_below_fill, clock, reset, scan_st.done && scan_st.found, CNT_W'(scan_idx) < fill_ff)
   `CIS_ASSERT_IMP(a_dirty_room, clock, reset, dirty_ff, fill_ff != CNT_W'(SLOTS))

endmodule

@@ tb/can_id_stats_checker.sv @@
module can_id_stats_checker (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_opcode,
   input  logic [cis_pkg::ID_W-1:0]           req_frame_id,
   input  logic [cis_pkg::LEN_W-1:0]          req_length_code,
   input  logic [cis_pkg::FLAGS_W-1:0]        req_frame_flags,
   input  logic [cis_pkg::STAMP_W-1:0]        req_frame_stamp,
   input  logic [cis_pkg::STAMP_W-1:0]        req_arrival_ms,
   input  logic [cis_pkg::DATA_W-1:0]         req_payload,

   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [1:0]                         rsp_status,
   input  logic [cis_pkg::SLOT_W-1:0]         rsp_slot,
   input  logic                               rsp_payload_changed,
   input  logic signed [cis_pkg::STAMP_W-1:0] rsp_arrival_delta,
   input  logic signed [cis_pkg::STAMP_W-1:0] rsp_stamp_delta,
   input  logic signed [cis_pkg::STAMP_W-1:0] rsp_arrival_average,
   input  logic signed [cis_pkg::STAMP_W-1:0] rsp_stamp_average,
   input  logic [cis_pkg::LEN_W-1:0]          rsp_stored_length,
   input  logic [cis_pkg::FLAGS_W-1:0]        rsp_stored_flags,
   input  logic [cis_pkg::STAMP_W-1:0]        rsp_stored_stamp,
   input  logic [cis_pkg::DATA_W-1:0]         rsp_stored_payload,

   output int                                 fail_count,
   output int                                 pending,
   output int                                 results_checked,
   output int                                 full_results
);
   import cis_pkg::*;

   localparam int TABLE_SLOTS = SLOTS_DEF;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic                changed;
      entry_type           contents;
   } slot_report_type;

   logic [ID_W-1:0] id_store    [TABLE_SLOTS];
   entry_type       entry_store [TABLE_SLOTS];
   slot_report_type awaited_reports [$];
   slot_report_type oldest;
   int              n;

   // (2*delta + 3*old) / 5 on signed 32-bit values, truncated toward zero
   function automatic logic [STAMP_W-1:0] moving_average(input logic [STAMP_W-1:0] delta,
                                                          input logic [STAMP_W-1:0] old);
      longint acc;
      acc = (2 * longint'($signed(delta)) + 3 * longint'($signed(old))) / 5;
      return acc[STAMP_W-1:0];
   endfunction

   function automatic slot_report_type predict_frame(input logic op,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [LEN_W-1:0] len,
                                                     input logic [FLAGS_W-1:0] flags,
                                                     input logic [STAMP_W-1:0] stamp,
                                                     input logic [STAMP_W-1:0] arrival,
                                                     input logic [DATA_W-1:0] data);
      slot_report_type rep;
      entry_type       e;
      int              hit;
      int              i;
      rep = '0;
      hit = -1;
      for (i = 0; i < TABLE_SLOTS; i++)
         if (hit < 0 && (id_store[i] == '0 || id_store[i] == id))
            hit = i;
      if (hit < 0) begin
         rep.status = STAT_FULL;
         return rep;
      end
      rep.status = (id_store[hit] == '0) ? STAT_EMPTY : STAT_MATCH;
      e = entry_store[hit];
      if (op == OP_RECEIVE) begin
         id_store[hit]   = id;
         rep.changed     = (e.payload != data);
         e.payload       = data;
         e.length        = len;
         e.flags         = flags;
         e.delta_arrival = arrival - e.last_arrival;
         e.delta_stamp   = stamp - e.stamp;
         e.last_arrival  = arrival;
         e.stamp         = stamp;
         e.avg_arrival   = moving_average(e.delta_arrival, e.avg_arrival);
         e.avg_stamp     = moving_average(e.delta_stamp, e.avg_stamp);
         entry_store[hit] = e;
      end
      rep.slot     = hit[SLOT_W-1:0];
      rep.contents = e;
      return rep;
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (n = 0; n < TABLE_SLOTS; n++) begin
            id_store[n]    = '0;
            entry_store[n] = '0;
         end
         awaited_reports.delete();
      end else begin
         // result leaving now belongs to an earlier word, so check before predicting
         if (rsp_valid && !rsp_stall) begin
            if (awaited_reports.size() == 0) begin
               $error("result word arrived with nothing outstanding");
               fail_count++;
            end else begin
               oldest = awaited_reports.pop_front();
               results_checked++;
               if (oldest.status == STAT_FULL)
                  full_results++;
               compare_field("status", 64'(oldest.status), 64'(rsp_status));
               compare_field("slot", 64'(oldest.slot), 64'(rsp_slot));
               compare_field("payload_changed", 64'(oldest.changed),
                             64'(rsp_payload_changed));
               compare_field("arrival_delta", 64'(oldest.contents.delta_arrival),
                             64'($unsigned(rsp_arrival_delta)));
               compare_field("stamp_delta", 64'(oldest.contents.delta_stamp),
                             64'($unsigned(rsp_stamp_delta)));
               compare_field("arrival_average", 64'(oldest.contents.avg_arrival),
                             64'($unsigned(rsp_arrival_average)));
               compare_field("stamp_average", 64'(oldest.contents.avg_stamp),
                             64'($unsigned(rsp_stamp_average)));
               compare_field("stored_length", 64'(oldest.contents.length),
                             64'(rsp_stored_length));
               compare_field("stored_flags", 64'(oldest.contents.flags),
                             64'(rsp_stored_flags));
               compare_field("stored_stamp", 64'(oldest.contents.stamp),
                             64'(rsp_stored_stamp));
               compare_field("stored_payload", oldest.contents.payload, rsp_stored_payload);
            end
         end
         if (req_valid && !req_stall)
            awaited_reports.push_back(predict_frame(req_opcode, req_frame_id,
                                                    req_length_code, req_frame_flags,
                                                    req_frame_stamp, req_arrival_ms,
                                                    req_payload));
      end
      pending = awaited_reports.size();
   end

endmodule

@@ tb/tb_can_id_stats_table_top.sv @@
// Stimulus and verdict for the CAN identifier statistics table.
// The checker beside the block does all prediction and comparison; this module only
// makes words, paces both channels and reports the outcome.
module tb_can_id_stats_table_top;
   import cis_pkg::*;

   localparam int POOL_SIZE    = 72;    // more identifiers than slots, so the table fills
   localparam int RANDOM_WORDS = 1530;
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 100;   // idle time after the last result is back

   typedef enum int {
      FLOW_FREE,      // never stalls
      FLOW_LIGHT,     // stalls now and then
      FLOW_HEAVY,     // stalls most cycles
      FLOW_TOGGLE     // alternates every cycle
   } stall_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_opcode = OP_RECEIVE;
   logic [ID_W-1:0]       req_frame_id = '0;
   logic [LEN_W-1:0]      req_length_code = '0;
   logic [FLAGS_W-1:0]    req_frame_flags = '0;
   logic [STAMP_W-1:0]    req_frame_stamp = '0;
   logic [STAMP_W-1:0]    req_arrival_ms = '0;
   logic [DATA_W-1:0]     req_payload = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_status;
   logic [SLOT_W-1:0]     rsp_slot;
   logic                  rsp_payload_changed;
   logic signed [STAMP_W-1:0] rsp_arrival_delta;
   logic signed [STAMP_W-1:0] rsp_stamp_delta;
   logic signed [STAMP_W-1:0] rsp_arrival_average;
   logic signed [STAMP_W-1:0] rsp_stamp_average;
   logic [LEN_W-1:0]      rsp_stored_length;
   logic [FLAGS_W-1:0]    rsp_stored_flags;
   logic [STAMP_W-1:0]    rsp_stored_stamp;
   logic [DATA_W-1:0]     rsp_stored_payload;

   int                    fail_count;
   int                    pending;
   int                    results_checked;
   int                    full_results;

   // stimulus bookkeeping
   logic [ID_W-1:0]       id_pool   [POOL_SIZE];
   logic [DATA_W-1:0]     last_data [POOL_SIZE];
   logic [STAMP_W-1:0]    now_ms;
   logic [STAMP_W-1:0]    stamp_clock;
   int                    words_sent = 0;
   int                    queries_sent = 0;
   int                    burst_left = 0;
   logic                  hold_request = 1'b0;
   int                    quiet_cycles = 0;

   // 12-unit clock period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   can_id_stats_table_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_frame_id        (req_frame_id),
      .req_length_code     (req_length_code),
      .req_frame_flags     (req_frame_flags),
      .req_frame_stamp     (req_frame_stamp),
      .req_arrival_ms      (req_arrival_ms),
      .req_payload         (req_payload),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_slot            (rsp_slot),
      .rsp_payload_changed (rsp_payload_changed),
      .rsp_arrival_delta   (rsp_arrival_delta),
      .rsp_stamp_delta     (rsp_stamp_delta),
      .rsp_arrival_average (rsp_arrival_average),
      .rsp_stamp_average   (rsp_stamp_average),
      .rsp_stored_length   (rsp_stored_length),
      .rsp_stored_flags    (rsp_stored_flags),
      .rsp_stored_stamp    (rsp_stored_stamp),
      .rsp_stored_payload  (rsp_stored_payload)
   );

   can_id_stats_checker stats_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_frame_id        (req_frame_id),
      .req_length_code     (req_length_code),
      .req_frame_flags     (req_frame_flags),
      .req_frame_stamp     (req_frame_stamp),
      .req_arrival_ms      (req_arrival_ms),
      .req_payload         (req_payload),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_slot            (rsp_slot),
      .rsp_payload_changed (rsp_payload_changed),
      .rsp_arrival_delta   (rsp_arrival_delta),
      .rsp_stamp_delta     (rsp_stamp_delta),
      .rsp_arrival_average (rsp_arrival_average),
      .rsp_stamp_average   (rsp_stamp_average),
      .rsp_stored_length   (rsp_stored_length),
      .rsp_stored_flags    (rsp_stored_flags),
      .rsp_stored_stamp    (rsp_stored_stamp),
      .rsp_stored_payload  (rsp_stored_payload),
      .fail_count          (fail_count),
      .pending             (pending),
      .results_checked     (results_checked),
      .full_results        (full_results)
   );

   // Offer one word and wait for the handshake. Called at a falling edge, returns at
   // the falling edge after acceptance with valid still high, so a following word in
   // the same burst goes out without valid dropping in between.
   task automatic send_word(input logic op, input logic [ID_W-1:0] id,
                            input logic [LEN_W-1:0] len, input logic [FLAGS_W-1:0] flags,
                            input logic [STAMP_W-1:0] stamp,
                            input logic [STAMP_W-1:0] arrival,
                            input logic [DATA_W-1:0] data);
      req_opcode      = op;
      req_frame_id    = id;
      req_length_code = len;
      req_frame_flags = flags;
      req_frame_stamp = stamp;
      req_arrival_ms  = arrival;
      req_payload     = data;
      req_valid       = 1'b1;
      words_sent++;
      if (op == OP_QUERY)
         queries_sent++;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   task automatic go_idle(input int cycles);
      req_valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // sender pause: nothing offered until every outstanding result is back
   task automatic drain_results();
      req_valid = 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   // bursts of random length; about a quarter of bursts follow on with no gap
   task automatic pace_sender();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0)
            go_idle($urandom_range(1, 20));
      end
      burst_left--;
   endtask

   // Receiver: stall pattern changes mode every so often; on request it holds off for a
   // long stretch so the block backs up and stalls its input.
   initial begin
      stall_mode_type mode;
      int             mode_left;
      mode      = FLOW_FREE;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall    = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         case (mode)
            FLOW_FREE:  rsp_stall = 1'b0;
            FLOW_LIGHT: rsp_stall = ($urandom_range(0, 3) == 0);
            FLOW_HEAVY: rsp_stall = ($urandom_range(0, 3) != 0);
            default:    rsp_stall = ~rsp_stall;
         endcase
      end
   end

   // Watchdog: too long without a handshake on either channel means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("can_id_stats_table_top test failed");
            $finish;
         end
      end
   end

   initial begin
      int              i;
      int              j;
      int              k;
      int              active;
      int              pick;
      int              choice;
      logic [ID_W-1:0] cand;
      logic            clash;

      // identifier pool: extremes and alternating patterns first, the rest random and
      // distinct, never zero
      id_pool[0] = '1;
      id_pool[1] = 29'h1;
      id_pool[2] = 29'h0AAA_AAAA;
      id_pool[3] = 29'h1555_5555;
      for (i = 4; i < POOL_SIZE; i++) begin
         clash = 1'b1;
         while (clash) begin
            cand  = ID_W'($urandom_range(1, 536870911));
            clash = 1'b0;
            for (j = 0; j < i; j++)
               if (id_pool[j] == cand)
                  clash = 1'b1;
         end
         id_pool[i] = cand;
      end
      for (i = 0; i < POOL_SIZE; i++)
         last_data[i] = {$urandom, $urandom};
      now_ms      = $urandom;
      stamp_clock = $urandom;

      repeat (9) @(negedge clock);
      reset = 1'b0;

      // ---- directed words on an empty table ----
      // query of an empty table lands on slot 0, all zero
      send_word(OP_QUERY, 29'h5, '0, '0, '0, '0, '0);
      // identifier zero with every field at its maximum: written, slot stays empty
      send_word(OP_RECEIVE, '0, '1, '1, '1, '1, '1);
      send_word(OP_QUERY, '0, '0, '0, '0, '0, '0);
      // top identifier takes that slot and inherits its contents
      send_word(OP_RECEIVE, id_pool[0], '0, '0, '0, '0, '0);
      // same payload again, then most negative deltas
      send_word(OP_RECEIVE, id_pool[0], 4'h8, 16'h8000, 32'h8000_0000, 32'h8000_0000, '0);
      send_word(OP_RECEIVE, id_pool[0], 4'h1, 16'h0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                64'h8000_0000_0000_0000);
      send_word(OP_RECEIVE, id_pool[0], 4'h7, 16'h7FFF, 32'hFFFF_FFFF, 32'h0000_0005,
                64'h0000_0000_0000_0001);
      // the stamp clock wraps past zero, the arrival clock steps back
      send_word(OP_RECEIVE, id_pool[0], 4'hE, 16'hFFFE, 32'h0000_0000, 32'h0000_0003,
                64'h0000_0000_0000_0001);
      send_word(OP_QUERY, id_pool[0], '1, '1, '1, '1, '1);
      // unknown identifier query returns the next empty slot
      send_word(OP_QUERY, id_pool[1], '0, '0, '0, '0, '0);
      send_word(OP_RECEIVE, id_pool[1], '0, '0, '0, '0, '0);
      send_word(OP_RECEIVE, id_pool[1], 4'h3, 16'h5A5A, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                64'h0123_4567_89AB_CDEF);
      send_word(OP_RECEIVE, id_pool[1], 4'hC, 16'hA5A5, 32'hFFFF_FFFE, 32'hFFFF_FFFE,
                64'hFEDC_BA98_7654_3210);
      // zero identifier again, then a real one picks up its leftover statistics
      send_word(OP_RECEIVE, '0, 4'h9, 16'h1234, 32'h1000_0000, 32'hF000_0000,
                64'hAAAA_5555_AAAA_5555);
      send_word(OP_QUERY, '0, '0, '0, '0, '0, '0);
      send_word(OP_RECEIVE, id_pool[2], 4'h2, 16'h00FF, 32'h1000_0100, 32'hF000_0040,
                64'hAAAA_5555_AAAA_5555);
      send_word(OP_RECEIVE, id_pool[3], 4'h5, 16'hFF00, 32'h0000_0010, 32'h0000_0020,
                64'h5555_AAAA_5555_AAAA);
      send_word(OP_QUERY, 29'h123_4567, '0, '0, '0, '0, '0);

      drain_results();

      // ---- random words ----
      // The pool in use grows with time so slots fill one by one; past 64 distinct
      // identifiers the table is full and new identifiers are refused from then on.
      for (k = 0; k < RANDOM_WORDS; k++) begin
         if (k == 400 || k == 1200)
            hold_request = 1'b1;
         if (k == 800)
            drain_results();
         pace_sender();
         active = 4 + k / 14;
         if (active > POOL_SIZE)
            active = POOL_SIZE;
         pick   = $urandom_range(0, active - 1);
         choice = $urandom_range(0, 99);
         now_ms      = now_ms + $urandom_range(0, 300);
         stamp_clock = stamp_clock + $urandom_range(0, 40000);
         if (choice < 65) begin
            // ordinary traffic: clocks move forward, payload often unchanged
            if ($urandom_range(0, 1) == 0)
               last_data[pick] = {$urandom, $urandom};
            send_word(OP_RECEIVE, id_pool[pick], LEN_W'($urandom_range(0, 15)),
                      FLAGS_W'($urandom_range(0, 65535)), stamp_clock, now_ms,
                      last_data[pick]);
         end else if (choice < 80) begin
            send_word(OP_QUERY, id_pool[pick], LEN_W'($urandom_range(0, 15)),
                      FLAGS_W'($urandom_range(0, 65535)), $urandom, $urandom,
                      {$urandom, $urandom});
         end else if (choice < 90) begin
            // known identifier, every other field random
            send_word(OP_RECEIVE, id_pool[pick], LEN_W'($urandom_range(0, 15)),
                      FLAGS_W'($urandom_range(0, 65535)), $urandom, $urandom,
                      {$urandom, $urandom});
         end else if (choice < 93) begin
            send_word(OP_RECEIVE, '0, LEN_W'($urandom_range(0, 15)),
                      FLAGS_W'($urandom_range(0, 65535)), $urandom, $urandom,
                      {$urandom, $urandom});
         end else begin
            // query of a stray identifier, sometimes zero
            cand = ($urandom_range(0, 3) == 0) ? '0 : ID_W'($urandom_range(1, 536870911));
            send_word(OP_QUERY, cand, LEN_W'($urandom_range(0, 15)),
                      FLAGS_W'($urandom_range(0, 65535)), $urandom, $urandom,
                      {$urandom, $urandom});
         end
      end

      req_valid = 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words (%0d queries); %0d results checked, %0d on a full table.",
               words_sent, queries_sent, results_checked, full_results);
      if (fail_count == 0)
         $display("can_id_stats_table_top test passed");
      else
         $display("can_id_stats_table_top test failed");
      $finish;
   end

endmodule
